[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the video sync segment generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Immediate-implication check, clocked by clk, off during reset.
`define VSSG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vssg assertion failed");

// Next-cycle implication check, clocked by clk, off during reset.
`define VSSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vssg assertion failed");

`else

`define VSSG_ASSERT_IMPL(label, ante, cons)
`define VSSG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/vssg_pkg.sv]
// ----------------------------------------------------------------------------
// vssg_pkg
// Types, register indexes and helpers for the video sync segment generator.
// ----------------------------------------------------------------------------
package vssg_pkg;

    localparam int SPAN_W      = 16;
    localparam int COUNT_W     = 12;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int SEG_OVERHEAD = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_H_ACTIVE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_H_FRONT  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_H_SYNC   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_H_BACK   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_V_ACTIVE = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_V_FRONT  = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_V_SYNC   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_V_BACK   = 4'd7;

    typedef enum logic [1:0] {
        SEG_ACTIVE = 2'd0,
        SEG_FRONT  = 2'd1,
        SEG_SYNC   = 2'd2,
        SEG_BACK   = 2'd3
    } seg_t;

    typedef enum logic [1:0] {
        PH_ACTIVE = 2'd0,
        PH_FRONT  = 2'd1,
        PH_SYNC   = 2'd2,
        PH_BACK   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [3:0][SPAN_W-1:0]  h_span;
        logic [3:0][COUNT_W-1:0] v_count;
        logic [3:0]              has_lines;
        logic                    err;
    } cfg_t;

    typedef struct packed {
        logic              hsync_level;
        logic              vsync_level;
        logic              display_enable;
        logic [SPAN_W-1:0] segment_delay;
        logic              last_of_line;
        logic              last_of_frame;
        logic              config_error;
    } res_t;

    // next phase after p that holds lines, wrapping; active phase if none
    function automatic phase_t next_phase(input logic [3:0] has_lines, input phase_t p);
        logic [1:0] q;
        phase_t     r;
        r = PH_ACTIVE;
        for (int k = 4; k >= 1; k--)
        begin
            q = 2'(int'(p) + k);
            if (has_lines[q])
                r = phase_t'(q);
        end
        return r;
    endfunction

endpackage

[sv/vssg_cfg.sv]
// ----------------------------------------------------------------------------
// vssg_cfg
// Timing register file with validity check of the programmed spans and line counts.
// ----------------------------------------------------------------------------
module vssg_cfg #(
    parameter int SPAN_BITS = 16,
    parameter int LINE_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [vssg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [vssg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output vssg_pkg::cfg_t                     cfg
);
    import vssg_pkg::*;

    localparam int SW = (SPAN_BITS < SPAN_W) ? SPAN_BITS : SPAN_W;
    localparam int LW = (LINE_BITS < COUNT_W) ? LINE_BITS : COUNT_W;
    localparam logic [SPAN_W-1:0]  SPAN_MASK = SPAN_W'((64'd1 << SW) - 64'd1);
    localparam logic [COUNT_W-1:0] LINE_MASK = COUNT_W'((64'd1 << LW) - 64'd1);
    localparam logic [SPAN_W-1:0]  MIN_SPAN  = SPAN_W'(SEG_OVERHEAD);

    logic [3:0][SPAN_W-1:0]  h_span_reg;
    logic [3:0][COUNT_W-1:0] v_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_span_reg[0]  <= 16'd640;
            h_span_reg[1]  <= 16'd16;
            h_span_reg[2]  <= 16'd96;
            h_span_reg[3]  <= 16'd48;
            v_count_reg[0] <= 12'd480;
            v_count_reg[1] <= 12'd10;
            v_count_reg[2] <= 12'd2;
            v_count_reg[3] <= 12'd33;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_H_ACTIVE: h_span_reg[0]  <= cfg_data & SPAN_MASK;
                REG_H_FRONT:  h_span_reg[1]  <= cfg_data & SPAN_MASK;
                REG_H_SYNC:   h_span_reg[2]  <= cfg_data & SPAN_MASK;
                REG_H_BACK:   h_span_reg[3]  <= cfg_data & SPAN_MASK;
                REG_V_ACTIVE: v_count_reg[0] <= cfg_data[COUNT_W-1:0] & LINE_MASK;
                REG_V_FRONT:  v_count_reg[1] <= cfg_data[COUNT_W-1:0] & LINE_MASK;
                REG_V_SYNC:   v_count_reg[2] <= cfg_data[COUNT_W-1:0] & LINE_MASK;
                REG_V_BACK:   v_count_reg[3] <= cfg_data[COUNT_W-1:0] & LINE_MASK;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.h_span  = h_span_reg;
        cfg.v_count = v_count_reg;
        for (int i = 0; i < 4; i++)
            cfg.has_lines[i] = (v_count_reg[i] != '0);
        // front porch may be zero (skipped); every other span needs the overhead
        cfg.err = (h_span_reg[0] < MIN_SPAN) || (h_span_reg[2] < MIN_SPAN) ||
                  (h_span_reg[3] < MIN_SPAN) ||
                  ((h_span_reg[1] != '0) && (h_span_reg[1] < MIN_SPAN)) ||
                  (cfg.has_lines == 4'b0000);
    end

endmodule

[sv/vssg_seq.sv]
// ----------------------------------------------------------------------------
// vssg_seq
// Raster position state and segment decode for one item.
// ----------------------------------------------------------------------------
module vssg_seq #(
    parameter int HSYNC_ACTIVE_HIGH = 0,
    parameter int VSYNC_ACTIVE_HIGH = 0,
    parameter int LINE_BITS         = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  logic           restart,
    input  vssg_pkg::cfg_t cfg,
    output vssg_pkg::res_t res
);
    import vssg_pkg::*;

    localparam int LW = (LINE_BITS < COUNT_W) ? LINE_BITS : COUNT_W;
    localparam logic HS_ON = 1'(HSYNC_ACTIVE_HIGH);
    localparam logic VS_ON = 1'(VSYNC_ACTIVE_HIGH);

    phase_t        phase_reg, phase_next;
    logic [LW-1:0] line_reg, line_next;
    seg_t          seg_reg, seg_next;

    phase_t             p0, p;
    logic [COUNT_W-1:0] line0, line;
    logic [COUNT_W:0]   line_inc;
    seg_t               s0, s;
    logic [SPAN_W-1:0]  span;
    logic               later_lines;
    logic               front_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ACTIVE;
            line_reg  <= '0;
            seg_reg   <= SEG_ACTIVE;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            line_reg  <= line_next;
            seg_reg   <= seg_next;
        end
    end

    always_comb
    begin
        front_empty = (cfg.h_span[1] == '0);
        p0    = restart ? PH_ACTIVE  : phase_reg;
        line0 = restart ? '0 : COUNT_W'(line_reg);
        s0    = restart ? SEG_ACTIVE : seg_reg;

        // position may be stale after a reconfiguration
        if (line0 >= cfg.v_count[p0])
        begin
            p    = next_phase(cfg.has_lines, p0);
            line = '0;
        end
        else
        begin
            p    = p0;
            line = line0;
        end
        s = (s0 == SEG_FRONT && front_empty) ? SEG_SYNC : s0;

        span     = cfg.h_span[s];
        line_inc = {1'b0, line} + 1'b1;
        later_lines = 1'b0;
        for (int q = 1; q < 4; q++)
            if (q > int'(p) && cfg.has_lines[q])
                later_lines = 1'b1;

        res.hsync_level    = (s == SEG_SYNC) ? HS_ON : !HS_ON;
        res.vsync_level    = (p == PH_SYNC)  ? VS_ON : !VS_ON;
        res.display_enable = (p == PH_ACTIVE) && (s == SEG_ACTIVE);
        res.segment_delay  = span - SPAN_W'(SEG_OVERHEAD);
        res.last_of_line   = (s == SEG_BACK);
        res.last_of_frame  = (s == SEG_BACK) && (line_inc == {1'b0, cfg.v_count[p]}) &&
                             !later_lines;
        res.config_error   = 1'b0;

        phase_next = p;
        line_next  = line[LW-1:0];
        unique case (s)
            SEG_BACK:
            begin
                seg_next = SEG_ACTIVE;
                if (line_inc >= {1'b0, cfg.v_count[p]})
                begin
                    phase_next = next_phase(cfg.has_lines, p);
                    line_next  = '0;
                end
                else
                    line_next = line_inc[LW-1:0];
            end
            SEG_ACTIVE: seg_next = front_empty ? SEG_SYNC : SEG_FRONT;
            SEG_FRONT:  seg_next = SEG_SYNC;
            SEG_SYNC:   seg_next = SEG_BACK;
            default:    seg_next = SEG_ACTIVE;
        endcase

        if (cfg.err)
        begin
            res        = '0;
            res.config_error = 1'b1;
            phase_next = p0;
            line_next  = line0[LW-1:0];
            seg_next   = s0;
        end
    end

endmodule

[sv/video_sync_segment_generator.sv]
// ----------------------------------------------------------------------------
// video_sync_segment_generator
// Emits the next horizontal timing segment of a raster frame for each item.
//
// Input channel (in_valid / in_stall / restart): each item requests one
// segment; restart = 1 rewinds to the first segment of the frame first.
// Output channel (out_valid / out_stall): one result item per request with
// sync levels, display enable, span minus 3 and line/frame end marks.
// The user writes timing registers through cfg_write / cfg_index / cfg_data
// only while the block is idle; it does not enforce this. Indexes above 7
// are ignored. Each item passes the input register, then the output register.
// Throughput: one item per cycle unless stalled; the position counters update
// once per item in a single registered step between the two registers.
// A stalled result holds in the output register; the input register still
// drains into it as soon as the result is taken, so in_stall rises only
// when both registers are full.
// Reset clears both valid flags and rewinds to the first segment;
// timing registers return to 640/16/96/48 pixels and 480/10/2/33 lines.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module video_sync_segment_generator #(
    parameter int HSYNC_ACTIVE_HIGH = 0,
    parameter int VSYNC_ACTIVE_HIGH = 0,
    parameter int SPAN_BITS         = 16,
    parameter int LINE_BITS         = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [vssg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vssg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hsync_level,
    output logic                              vsync_level,
    output logic                              display_enable,
    output logic [vssg_pkg::SPAN_W-1:0]       segment_delay,
    output logic                              last_of_line,
    output logic                              last_of_frame,
    output logic                              config_error
);
    import vssg_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic in_valid_reg;
    logic restart_reg;
    logic out_valid_reg;
    logic advance;
    logic fire;

    vssg_cfg #(
        .SPAN_BITS (SPAN_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vssg_seq #(
        .HSYNC_ACTIVE_HIGH (HSYNC_ACTIVE_HIGH),
        .VSYNC_ACTIVE_HIGH (VSYNC_ACTIVE_HIGH),
        .LINE_BITS         (LINE_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .restart (restart_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
            restart_reg <= restart;
        if (fire)
            res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign hsync_level    = res_reg.hsync_level;
    assign vsync_level    = res_reg.vsync_level;
    assign display_enable = res_reg.display_enable;
    assign segment_delay  = res_reg.segment_delay;
    assign last_of_line   = res_reg.last_of_line;
    assign last_of_frame  = res_reg.last_of_frame;
    assign config_error   = res_reg.config_error;

    `VSSG_ASSERT_IMPL(a_err_clears_fields, out_valid && config_error, !hsync_level && !vsync_level && !display_enable && segment_delay == '0 && !last_of_line)
    `VSSG_ASSERT_IMPL(a_frame_end_is_line_end, out_valid && last_of_frame, last_of_line)
    `VSSG_ASSERT_IMPL(a_de_outside_hsync, out_valid && display_enable, hsync_level == !1'(HSYNC_ACTIVE_HIGH) && !last_of_line)
    `VSSG_ASSERT_NEXT(a_fire_fills_output, fire, out_valid)

endmodule
